// ----- hw/rtl/pni_pkg.sv -----
// Shared constants, types and functions of the pixel noise injector.
`timescale 1ns / 1ps

package pni_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int PIX_W          = 32;
  localparam int AMP_W          = 7;
  localparam int SEED_W         = 32;
  localparam int ADDR_W         = 3;
  localparam int DATA_W         = 32;
  localparam int MASK_W         = AMP_W + 1;
  localparam int NOISE_W        = MASK_W + 2;

  localparam logic [31:0] ROW_MULT = 32'd2654435761;
  localparam logic [31:0] COL_MULT = 32'd805459861;

  typedef enum logic {
    REG_AMPLITUDE = 1'b0,
    REG_SEED      = 1'b1
  } reg_idx_t;

  function automatic logic [31:0] xorshift_step(input logic [31:0] s);
    logic [31:0] t;
    t = s ^ (s << 13);
    t = t ^ (t >> 17);
    t = t ^ (t << 5);
    return t;
  endfunction

  function automatic logic [MASK_W-1:0] noise_mask(input logic [AMP_W-1:0] amp);
    logic [AMP_W-1:0] sm;
    sm = amp;
    for (int i = 1; i < AMP_W; i++) begin
      sm = sm | (sm >> 1);
    end
    if (amp == '0) begin
      return '0;
    end
    return {sm, 1'b1};
  endfunction

  function automatic logic [7:0] clamp_channel(input logic signed [NOISE_W-1:0] v);
    if (v < 0) begin
      return 8'd0;
    end
    if (v > NOISE_W'(255)) begin
      return 8'hFF;
    end
    return v[7:0];
  endfunction

endpackage

// ----- hw/rtl/pixel_noise_injector.sv -----
// Top level of the pixel noise injector: reseed, generator step, noise add and clamp.
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// in        in_valid / in_ready    in_pixel_in, in_row_start, in_row_index, in_column_start
// out       out_valid / out_ready  out_pixel_out
// cfg       APB write/read         paddr, pwdata, prdata (amplitude at 0x0, seed at 0x4)
//
// One item per clock unless out stalls; items pass the input, then the output register.
// The reseed products are formed ahead of the input register; the generator step and
// the noise add share the cycle into the output register, which is the loop on state.
// Synchronous active-low reset clears valids, config registers and generator state to zero.
// A stalled output holds both stages; in_ready stays high while the input stage is free.

module pixel_noise_injector #(
  parameter int COORD_BITS = pni_pkg::COORD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [pni_pkg::PIX_W-1:0]  in_pixel_in,
  input  logic                       in_row_start,
  input  logic [COORD_BITS-1:0]      in_row_index,
  input  logic [COORD_BITS-1:0]      in_column_start,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [pni_pkg::PIX_W-1:0]  out_pixel_out,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pni_pkg::ADDR_W-1:0] paddr,
  input  logic [pni_pkg::DATA_W-1:0] pwdata,
  output logic [pni_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import pni_pkg::*;

  logic [AMP_W-1:0]  amp_r;
  logic [SEED_W-1:0] seed_r;
  logic [31:0]       state_r, state_nxt;

  logic              s1_valid_r;
  logic [PIX_W-1:0]  s1_pixel_r;
  logic              s1_start_r;
  logic [31:0]       s1_reseed_r, reseed_nxt;

  logic              out_valid_r;
  logic [PIX_W-1:0]  out_pixel_r, out_pixel_nxt;

  logic              advance;
  logic              accept;
  logic              cfg_write;
  reg_idx_t          cfg_idx;

  logic [31:0]              row_prod, col_prod;
  logic [MASK_W-1:0]        mask;
  logic signed [NOISE_W-1:0] noise;
  logic signed [NOISE_W-1:0] r_sum, g_sum, b_sum;

  assign pready    = 1'b1;
  assign cfg_idx   = reg_idx_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    unique case (cfg_idx)
      REG_AMPLITUDE: prdata = DATA_W'(amp_r);
      REG_SEED:      prdata = DATA_W'(seed_r);
      default:       prdata = '0;
    endcase
  end

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = advance || !s1_valid_r;
  assign accept   = in_valid && in_ready;

  assign row_prod   = 32'(32'(in_row_index) * ROW_MULT);
  assign col_prod   = 32'(32'(in_column_start) * COL_MULT);
  assign reseed_nxt = xorshift_step(seed_r ^ row_prod ^ col_prod);

  assign state_nxt = xorshift_step(s1_start_r ? s1_reseed_r : state_r);
  assign mask      = noise_mask(amp_r);
  assign noise     = $signed({2'b00, state_nxt[MASK_W-1:0] & mask})
                   - $signed(NOISE_W'(amp_r));
  assign r_sum     = $signed(NOISE_W'(s1_pixel_r[23:16])) + noise;
  assign g_sum     = $signed(NOISE_W'(s1_pixel_r[15:8])) + noise;
  assign b_sum     = $signed(NOISE_W'(s1_pixel_r[7:0])) + noise;

  always_comb begin
    if (s1_pixel_r[31:24] == 8'd0) begin
      out_pixel_nxt = s1_pixel_r;
    end else begin
      out_pixel_nxt = {s1_pixel_r[31:24], clamp_channel(r_sum), clamp_channel(g_sum),
                       clamp_channel(b_sum)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amp_r       <= '0;
      seed_r      <= '0;
      state_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_idx)
          REG_AMPLITUDE: amp_r  <= pwdata[AMP_W-1:0];
          REG_SEED:      seed_r <= pwdata[SEED_W-1:0];
          default:       ;
        endcase
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
        if (s1_valid_r) begin
          state_r <= state_nxt;
        end
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel_r  <= in_pixel_in;
      s1_start_r  <= in_row_start;
      s1_reseed_r <= reseed_nxt;
    end
    if (advance && s1_valid_r) begin
      out_pixel_r <= out_pixel_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_out = out_pixel_r;

endmodule
